// ===== rtl/core/dgc_pkg.sv =====
package dgc_pkg;

  localparam int NUM_VERTICES = 64;
  localparam int VERTEX_W     = 6;
  localparam int SIZE_W       = 7;
  localparam int VW           = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int CNT_W        = $clog2(NUM_VERTICES + 1);
  localparam int SIZE_MAX     = (1 << SIZE_W) - 1;
  localparam int UPC_W        = 3;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CONN   = 2'd2,
    REQ_SIZE   = 2'd3
  } req_t;

  // row read source
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_A    = 2'd1,
    RD_B    = 2'd2,
    RD_FFS  = 2'd3
  } rd_sel_t;

  // row write-back: row a gets bit b, or row b gets bit a
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_A    = 2'd1,
    WR_B    = 2'd2
  } wr_sel_t;

  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_ALWAYS   = 3'd1,
    JC_DISPATCH = 3'd2,
    JC_ABAD     = 3'd3,
    JC_QBAD     = 3'd4,
    JC_LOOP     = 3'd5
  } jc_t;

  typedef struct packed {
    rd_sel_t            rd_sel;
    wr_sel_t            wr_sel;
    logic               init_q;
    logic               grow;
    logic               emit;
    jc_t                jc;
    logic [UPC_W-1:0]   tgt;
  } ucode_t;

  typedef struct packed {
    logic                    rd_en;
    logic [VW-1:0]           rd_addr;
    logic                    wr_en;
    logic [VW-1:0]           wr_addr;
    logic [NUM_VERTICES-1:0] wr_data;
  } adj_req_t;

  localparam logic [UPC_W-1:0] UA_IDLE = 3'd0;
  localparam logic [UPC_W-1:0] UA_UPD  = 3'd1;
  localparam logic [UPC_W-1:0] UA_WRA  = 3'd2;
  localparam logic [UPC_W-1:0] UA_RDB  = 3'd3;
  localparam logic [UPC_W-1:0] UA_WRB  = 3'd4;
  localparam logic [UPC_W-1:0] UA_QRY  = 3'd5;
  localparam logic [UPC_W-1:0] UA_GROW = 3'd6;
  localparam logic [UPC_W-1:0] UA_EMIT = 3'd7;

  function automatic ucode_t uw(input rd_sel_t rd, input wr_sel_t wr, input logic init_q,
                                input logic grow, input logic emit, input jc_t jc,
                                input logic [UPC_W-1:0] tgt);
    ucode_t w;
    w.rd_sel = rd;
    w.wr_sel = wr;
    w.init_q = init_q;
    w.grow   = grow;
    w.emit   = emit;
    w.jc     = jc;
    w.tgt    = tgt;
    return w;
  endfunction

  // control store
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
    ucode_t w;
    case (pc)
      UA_IDLE: w = uw(RD_NONE, WR_NONE, 1'b0, 1'b0, 1'b0, JC_DISPATCH, UA_IDLE);
      UA_UPD:  w = uw(RD_A,    WR_NONE, 1'b0, 1'b0, 1'b0, JC_ABAD,     UA_EMIT);
      UA_WRA:  w = uw(RD_NONE, WR_A,    1'b0, 1'b0, 1'b0, JC_NEXT,     UA_IDLE);
      UA_RDB:  w = uw(RD_B,    WR_NONE, 1'b0, 1'b0, 1'b0, JC_NEXT,     UA_IDLE);
      UA_WRB:  w = uw(RD_NONE, WR_B,    1'b0, 1'b0, 1'b0, JC_ALWAYS,   UA_EMIT);
      UA_QRY:  w = uw(RD_NONE, WR_NONE, 1'b1, 1'b0, 1'b0, JC_QBAD,     UA_EMIT);
      UA_GROW: w = uw(RD_FFS,  WR_NONE, 1'b0, 1'b1, 1'b0, JC_LOOP,     UA_GROW);
      UA_EMIT: w = uw(RD_NONE, WR_NONE, 1'b0, 1'b0, 1'b1, JC_ALWAYS,   UA_IDLE);
      default: w = uw(RD_NONE, WR_NONE, 1'b0, 1'b0, 1'b0, JC_ALWAYS,   UA_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry_of(input logic [1:0] t);
    logic [UPC_W-1:0] e;
    case (t) inside
      REQ_ADD, REQ_REMOVE: e = UA_UPD;
      REQ_CONN, REQ_SIZE:  e = UA_QRY;
      default:             e = UA_IDLE;
    endcase
    return e;
  endfunction

  function automatic logic in_range(input logic [VERTEX_W-1:0] v);
    return 32'(v) < NUM_VERTICES;
  endfunction

  function automatic logic [VW-1:0] vidx(input logic [VERTEX_W-1:0] v);
    return VW'(v);
  endfunction

endpackage

// ===== rtl/core/dgc_adj_mem.sv =====
module dgc_adj_mem
  import dgc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  adj_req_t                req,
  output logic [NUM_VERTICES-1:0] rd_row
);

  logic [NUM_VERTICES-1:0] mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] row_valid;
  logic [NUM_VERTICES-1:0] rd_q;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // rows never written read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_vld ? rd_q : '0;

endmodule

// ===== rtl/core/dynamic_graph_connectivity_core.sv =====
// Channel   Ports                                        Handshake
// request   req_type, vertex_a, vertex_b                 start && !busy
// result    connected, component_size                    done, one cycle
//
// Add or remove edge: read/modify/write of both rows between accept and done.
// Queries: the adjacency store gives one row a cycle and each reached
// vertex costs one row read.
// Synchronous reset clears the graph (per-row valid bits) at once; no clearing pass.
// The receiver cannot stall: done is high for one cycle and busy is low with it.
module dynamic_graph_connectivity_core
  import dgc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          req_type,
  input  logic [VERTEX_W-1:0] vertex_a,
  input  logic [VERTEX_W-1:0] vertex_b,
  output logic                done,
  output logic                connected,
  output logic [SIZE_W-1:0]   component_size
);

  logic [UPC_W-1:0]        pc;
  logic [UPC_W-1:0]        pc_next;
  ucode_t                  uc;
  logic [1:0]              type_q;
  logic [VERTEX_W-1:0]     a_q;
  logic [VERTEX_W-1:0]     b_q;
  logic                    q_ok;
  logic                    pend;
  logic [CNT_W-1:0]        cnt;
  logic [NUM_VERTICES-1:0] reached;
  logic [NUM_VERTICES-1:0] done_set;
  logic [NUM_VERTICES-1:0] cand;
  logic [NUM_VERTICES-1:0] lowest;
  logic [NUM_VERTICES-1:0] rd_row;
  logic [NUM_VERTICES-1:0] mod_row;
  logic [VW-1:0]           ffs_idx;
  logic                    cand_any;
  logic                    a_ok;
  logic                    b_ok;
  logic                    accept;
  logic                    take;
  logic [SIZE_W-1:0]       size_sat;
  adj_req_t                mreq;

  assign uc       = ucode_rom(pc);
  assign busy     = (pc != UA_IDLE);
  assign accept   = start && !busy;
  assign a_ok     = in_range(a_q);
  assign b_ok     = in_range(b_q);
  assign cand     = reached & ~done_set;
  assign cand_any = |cand;
  assign lowest   = cand & (~cand + NUM_VERTICES'(1));

  always_comb begin
    ffs_idx = '0;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      if (lowest[i]) begin
        ffs_idx = ffs_idx | VW'(i);
      end
    end
  end

  always_comb begin
    case (uc.jc)
      JC_NEXT:   take = 1'b0;
      JC_ALWAYS: take = 1'b1;
      JC_ABAD:   take = !(a_ok && b_ok);
      JC_QBAD:   take = !a_ok;
      JC_LOOP:   take = cand_any || pend;
      default:   take = 1'b0;
    endcase
    if (uc.jc == JC_DISPATCH) begin
      pc_next = accept ? entry_of(req_type) : pc;
    end else begin
      pc_next = take ? uc.tgt : pc + UPC_W'(1);
    end
  end

  // row a takes bit b on WR_A, row b takes bit a on WR_B
  always_comb begin
    mod_row = rd_row;
    if (uc.wr_sel == WR_B) begin
      mod_row[vidx(a_q)] = (type_q == REQ_ADD);
    end else begin
      mod_row[vidx(b_q)] = (type_q == REQ_ADD);
    end
  end

  always_comb begin
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = vidx(a_q);
    case (uc.rd_sel)
      RD_A: begin
        mreq.rd_en = 1'b1;
      end
      RD_B: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = vidx(b_q);
      end
      RD_FFS: begin
        mreq.rd_en   = cand_any;
        mreq.rd_addr = ffs_idx;
      end
      default: mreq.rd_en = 1'b0;
    endcase
    mreq.wr_en   = (uc.wr_sel != WR_NONE);
    mreq.wr_addr = (uc.wr_sel == WR_B) ? vidx(b_q) : vidx(a_q);
    mreq.wr_data = mod_row;
  end

  dgc_adj_mem u_adj (
    .clk    (clk),
    .rst    (rst),
    .req    (mreq),
    .rd_row (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= UA_IDLE;
      done     <= 1'b0;
      pend     <= 1'b0;
      q_ok     <= 1'b0;
      cnt      <= '0;
      reached  <= '0;
      done_set <= '0;
    end else begin
      pc   <= pc_next;
      done <= uc.emit;
      if (accept) begin
        q_ok <= 1'b0;
      end
      if (uc.init_q) begin
        reached  <= NUM_VERTICES'(1) << vidx(a_q);
        done_set <= '0;
        pend     <= 1'b0;
        cnt      <= '0;
        q_ok     <= a_ok;
      end
      if (uc.grow) begin
        // row read last cycle lands now; pick the next unvisited reached vertex
        reached <= reached | (pend ? rd_row : '0);
        pend    <= cand_any;
        if (cand_any) begin
          done_set <= done_set | lowest;
          cnt      <= cnt + CNT_W'(1);
        end
      end
    end
  end

  assign size_sat = (32'(cnt) > SIZE_MAX) ? SIZE_W'(SIZE_MAX) : SIZE_W'(cnt);

  always_ff @(posedge clk) begin
    if (accept) begin
      type_q <= req_type;
      a_q    <= vertex_a;
      b_q    <= vertex_b;
    end
    if (uc.emit) begin
      connected      <= q_ok && (type_q == REQ_CONN) && b_ok && reached[vidx(b_q)];
      component_size <= (q_ok && (type_q == REQ_SIZE)) ? size_sat : '0;
    end
  end

`ifndef SYNTH
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but sequencer did not leave idle");

  a_visited_reached: assert property (@(posedge clk) disable iff (rst)
    (done_set & ~reached) == '0)
    else $error("visited vertex outside reached set");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(done_set) == 32'(cnt))
    else $error("component count out of step with visited set");
`endif

endmodule
